// ===== rtl/ordered_array_engine_top_macros.svh =====
// ----------------------------------------------------------------------------
// Ordered array engine assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_ENGINE_TOP_MACROS_SVH
`define ORDERED_ARRAY_ENGINE_TOP_MACROS_SVH

// Same-cycle implication.
`define OAE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/oae_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered array engine package
// Command and status codes, sequencer states and the result beat type.
// ----------------------------------------------------------------------------
`default_nettype none

package oae_pkg;

  localparam int unsigned DepthDef     = 1024;
  localparam int unsigned DataWidthDef = 32;

  typedef enum logic [2:0] {
    CMD_APPEND  = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_EDIT    = 3'd2,
    CMD_DELETE  = 3'd3,
    CMD_SEARCH  = 3'd4,
    CMD_REVERSE = 3'd5,
    CMD_SORT    = 3'd6,
    CMD_READ    = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_BAD_INDEX = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_PUT,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_SR_RD,
    ST_SR_CMP,
    ST_RV_RI,
    ST_RV_RJ,
    ST_RV_WI,
    ST_RV_WJ,
    ST_SO_RK,
    ST_SO_LK,
    ST_SO_CMP,
    ST_SO_WK
  } state_e;

  typedef struct packed {
    status_e            status;
    logic [9:0]         found_position;
    logic signed [31:0] read_data;
    logic [10:0]        element_total;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/ordered_array_engine_top.sv =====
// ----------------------------------------------------------------------------
// Ordered array engine
// A packed list of signed words in one RAM with append, insert, edit, delete,
// search, reverse, sort and read commands.
// ----------------------------------------------------------------------------
// A command beat is taken on a rising edge with start high and busy low; each
// command returns exactly one result beat, flagged by done_o for a single
// cycle, and the receiver cannot stall it, so it must capture the beat on
// that edge. Timing is set by the single element RAM, which does one read
// and one write per cycle with registered read data. Append and edit (and
// every rejected command) finish in the cycle that takes the command, and
// read waits for the registered read data. Insert reads and writes each
// moved element and then writes the new value, and delete reads and writes
// each moved element. Search reads and compares each element scanned, and
// reverse reads and writes both elements of each swapped pair. Sort is an
// insertion sort that reads each key, compares and shifts larger elements
// and writes the key back, at a cost that is quadratic in the element count
// in the worst case. The result beat is registered, and the next command
// may be issued in the cycle that carries the result.
`default_nettype none

`include "ordered_array_engine_top_macros.svh"

module ordered_array_engine_top #(
  parameter int unsigned DEPTH      = oae_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = oae_pkg::DataWidthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         command_i,
  input  wire logic [9:0]         position_i,
  input  wire logic signed [31:0] operand_value_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic [9:0]              found_position_o,
  output logic signed [31:0]      read_data_o,
  output logic [10:0]             element_total_o
);

  localparam int unsigned Aw = $clog2(DEPTH);

  oae_pkg::result_t        res;
  logic                    mem_we, mem_re;
  logic [Aw-1:0]           mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0]   mem_wdata, mem_rdata;

  // The sequencer owns the element count and walks the store.
  oae_seq #(
    .Depth     (DEPTH),
    .DataWidth (DATA_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .cmd_i       (oae_pkg::cmd_e'(command_i)),
    .pos_i       (position_i),
    .val_i       (operand_value_i),
    .busy        (busy),
    .done_o      (done_o),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Element store; entries are only ever read below the count, so it needs
  // no clearing after reset.
  oae_ram #(
    .Width (DATA_WIDTH),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign status_o         = res.status;
  assign found_position_o = res.found_position;
  assign read_data_o      = res.read_data;
  assign element_total_o  = res.element_total;

  // A taken command either finishes at once or keeps the engine busy.
  `OAE_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done_o, "accepted command lost")
  // A result beat only appears once the engine is free again.
  `OAE_ASSERT_NOW(a_done_idle, done_o, !busy, "result beat while busy")
  // A missed search never reports a position.
  `OAE_ASSERT_NOW(a_miss_zero, done_o && (status_o == oae_pkg::STS_NOT_FOUND),
    found_position_o == 10'd0, "miss with nonzero position")
  // Error results, such as reads outside the list, return zero data.
  `OAE_ASSERT_NOW(a_bad_zero, done_o && (status_o != oae_pkg::STS_OK),
    read_data_o == 32'sd0, "error with nonzero data")

endmodule

`default_nettype wire

// ===== rtl/oae_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module oae_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned Aw   = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/oae_seq.sv =====
// ----------------------------------------------------------------------------
// Ordered array engine sequencer
// Walks the element store through the RAM's read and write ports and produces the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module oae_seq #(
  parameter int unsigned Depth     = oae_pkg::DepthDef,
  parameter int unsigned DataWidth = oae_pkg::DataWidthDef,
  localparam int unsigned Aw       = $clog2(Depth),
  localparam int unsigned Cw       = $clog2(Depth + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  input  wire oae_pkg::cmd_e           cmd_i,
  input  wire logic [9:0]              pos_i,
  input  wire logic signed [31:0]      val_i,
  output logic                         busy,
  output logic                         done_o,
  output oae_pkg::result_t             res_o,
  output logic                         mem_we_o,
  output logic [Aw-1:0]                mem_waddr_o,
  output logic [DataWidth-1:0]         mem_wdata_o,
  output logic                         mem_re_o,
  output logic [Aw-1:0]                mem_raddr_o,
  input  wire logic [DataWidth-1:0]    mem_rdata_i
);

  localparam int unsigned Mw = (Cw > 10) ? Cw : 10;

  oae_pkg::state_e  state_q, state_d;
  logic [Cw-1:0]    count_q, count_d;
  logic [Cw-1:0]    i_q, i_d, j_q, j_d, pos_q, pos_d;
  logic [DataWidth-1:0] val_q, val_d, key_q, key_d;
  logic             done_q, done_d;
  oae_pkg::result_t res_q, res_d;

  logic [Mw-1:0]    pos_w, cnt_w;
  logic [Cw:0]      i_p1, i_p2, j_p1;
  logic [DataWidth-1:0] val_in;

  assign pos_w  = Mw'(pos_i);
  assign cnt_w  = Mw'(count_q);
  assign i_p1   = {1'b0, i_q} + (Cw+1)'(1);
  assign i_p2   = {1'b0, i_q} + (Cw+1)'(2);
  assign j_p1   = {1'b0, j_q} + (Cw+1)'(1);
  assign val_in = DataWidth'(val_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oae_pkg::ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    j_q   <= j_d;
    pos_q <= pos_d;
    val_q <= val_d;
    key_q <= key_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    i_d         = i_q;
    j_d         = j_q;
    pos_d       = pos_q;
    val_d       = val_q;
    key_d       = key_q;
    done_d      = 1'b0;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = j_q[Aw-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = i_q[Aw-1:0];

    case (state_q)
      oae_pkg::ST_IDLE: begin
        if (start) begin
          res_d.status         = oae_pkg::STS_OK;
          res_d.found_position = '0;
          res_d.read_data      = '0;
          val_d = val_in;
          pos_d = Cw'(pos_i);
          case (cmd_i)
            oae_pkg::CMD_APPEND: begin
              done_d = 1'b1;
              if (count_q == Cw'(Depth)) begin
                res_d.status = oae_pkg::STS_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = count_q[Aw-1:0];
                mem_wdata_o = val_in;
                count_d     = count_q + Cw'(1);
              end
            end
            oae_pkg::CMD_INSERT: begin
              if (pos_w > cnt_w) begin
                done_d = 1'b1;
                res_d.status = oae_pkg::STS_BAD_INDEX;
              end else if (count_q == Cw'(Depth)) begin
                done_d = 1'b1;
                res_d.status = oae_pkg::STS_FULL;
              end else begin
                j_d     = count_q;
                state_d = oae_pkg::ST_INS_RD;
              end
            end
            oae_pkg::CMD_EDIT: begin
              done_d = 1'b1;
              if (pos_w >= cnt_w) begin
                res_d.status = oae_pkg::STS_BAD_INDEX;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = Aw'(pos_i);
                mem_wdata_o = val_in;
              end
            end
            oae_pkg::CMD_DELETE: begin
              if (pos_w >= cnt_w) begin
                done_d = 1'b1;
                res_d.status = oae_pkg::STS_BAD_INDEX;
              end else begin
                j_d     = Cw'(pos_i);
                state_d = oae_pkg::ST_DEL_RD;
              end
            end
            oae_pkg::CMD_SEARCH: begin
              if (count_q == '0) begin
                done_d = 1'b1;
                res_d.status = oae_pkg::STS_NOT_FOUND;
              end else begin
                j_d     = '0;
                state_d = oae_pkg::ST_SR_RD;
              end
            end
            oae_pkg::CMD_REVERSE: begin
              if (count_q <= Cw'(1)) begin
                done_d = 1'b1;
              end else begin
                i_d     = '0;
                j_d     = count_q - Cw'(1);
                state_d = oae_pkg::ST_RV_RI;
              end
            end
            oae_pkg::CMD_SORT: begin
              if (count_q <= Cw'(1)) begin
                done_d = 1'b1;
              end else begin
                i_d     = Cw'(1);
                state_d = oae_pkg::ST_SO_RK;
              end
            end
            default: begin
              if (pos_w >= cnt_w) begin
                done_d = 1'b1;
                res_d.status = oae_pkg::STS_BAD_INDEX;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = Aw'(pos_i);
                state_d     = oae_pkg::ST_RD_WAIT;
              end
            end
          endcase
        end
      end

      oae_pkg::ST_RD_WAIT: begin
        res_d.read_data = 32'(signed'(mem_rdata_i));
        done_d  = 1'b1;
        state_d = oae_pkg::ST_IDLE;
      end

      // Insert: move elements up from the top, then drop the new value in.
      oae_pkg::ST_INS_RD: begin
        if (j_q > pos_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = Aw'(j_q - Cw'(1));
          state_d     = oae_pkg::ST_INS_WR;
        end else begin
          state_d = oae_pkg::ST_INS_PUT;
        end
      end
      oae_pkg::ST_INS_WR: begin
        mem_we_o = 1'b1;
        j_d      = j_q - Cw'(1);
        state_d  = oae_pkg::ST_INS_RD;
      end
      oae_pkg::ST_INS_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q[Aw-1:0];
        mem_wdata_o = val_q;
        count_d     = count_q + Cw'(1);
        done_d      = 1'b1;
        state_d     = oae_pkg::ST_IDLE;
      end

      // Delete: move elements down from the hole to the end.
      oae_pkg::ST_DEL_RD: begin
        if (j_p1 < {1'b0, count_q}) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = Aw'(j_p1);
          state_d     = oae_pkg::ST_DEL_WR;
        end else begin
          count_d = count_q - Cw'(1);
          done_d  = 1'b1;
          state_d = oae_pkg::ST_IDLE;
        end
      end
      oae_pkg::ST_DEL_WR: begin
        mem_we_o = 1'b1;
        j_d      = Cw'(j_p1);
        state_d  = oae_pkg::ST_DEL_RD;
      end

      oae_pkg::ST_SR_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = j_q[Aw-1:0];
        state_d     = oae_pkg::ST_SR_CMP;
      end
      oae_pkg::ST_SR_CMP: begin
        if (mem_rdata_i == val_q) begin
          res_d.found_position = 10'(j_q);
          done_d  = 1'b1;
          state_d = oae_pkg::ST_IDLE;
        end else if (j_p1 < {1'b0, count_q}) begin
          j_d     = Cw'(j_p1);
          state_d = oae_pkg::ST_SR_RD;
        end else begin
          res_d.status = oae_pkg::STS_NOT_FOUND;
          done_d  = 1'b1;
          state_d = oae_pkg::ST_IDLE;
        end
      end

      // Reverse: swap the pair at i and j, then step both inward.
      oae_pkg::ST_RV_RI: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = i_q[Aw-1:0];
        state_d     = oae_pkg::ST_RV_RJ;
      end
      oae_pkg::ST_RV_RJ: begin
        key_d       = mem_rdata_i;
        mem_re_o    = 1'b1;
        mem_raddr_o = j_q[Aw-1:0];
        state_d     = oae_pkg::ST_RV_WI;
      end
      oae_pkg::ST_RV_WI: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = i_q[Aw-1:0];
        state_d     = oae_pkg::ST_RV_WJ;
      end
      oae_pkg::ST_RV_WJ: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = key_q;
        i_d         = Cw'(i_p1);
        j_d         = j_q - Cw'(1);
        if (i_p2 < {1'b0, j_q}) begin
          state_d = oae_pkg::ST_RV_RI;
        end else begin
          done_d  = 1'b1;
          state_d = oae_pkg::ST_IDLE;
        end
      end

      // Sort: insertion sort, the key at i sinks past larger elements.
      oae_pkg::ST_SO_RK: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = i_q[Aw-1:0];
        state_d     = oae_pkg::ST_SO_LK;
      end
      oae_pkg::ST_SO_LK: begin
        key_d       = mem_rdata_i;
        j_d         = i_q;
        mem_re_o    = 1'b1;
        mem_raddr_o = Aw'(i_q - Cw'(1));
        state_d     = oae_pkg::ST_SO_CMP;
      end
      oae_pkg::ST_SO_CMP: begin
        if ($signed(mem_rdata_i) > $signed(key_q)) begin
          mem_we_o = 1'b1;
          j_d      = j_q - Cw'(1);
          if (j_q > Cw'(1)) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = Aw'(j_q - Cw'(2));
          end else begin
            state_d = oae_pkg::ST_SO_WK;
          end
        end else begin
          state_d = oae_pkg::ST_SO_WK;
        end
      end
      oae_pkg::ST_SO_WK: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = key_q;
        if (i_p1 < {1'b0, count_q}) begin
          i_d     = Cw'(i_p1);
          state_d = oae_pkg::ST_SO_RK;
        end else begin
          done_d  = 1'b1;
          state_d = oae_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = oae_pkg::ST_IDLE;
      end
    endcase

    if (done_d) begin
      res_d.element_total = 11'(count_d);
    end
  end

  assign busy   = (state_q != oae_pkg::ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire
